@@ sv/greedy_delta_copy_insert_encoder_core_macros.svh @@
// assertion macros shared by the encoder rtl
// depends on nothing; included by files that carry assertions
`ifndef GREEDY_DELTA_COPY_INSERT_ENCODER_CORE_MACROS_SVH
`define GREEDY_DELTA_COPY_INSERT_ENCODER_CORE_MACROS_SVH

// same-cycle implication
`define GDCI_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GDCI_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/gdci_pkg.sv @@
`timescale 1ns / 1ps
// shared codes and types of the greedy copy/insert delta encoder
// depends on nothing
package gdci_pkg;

	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_ENCODE = 1'b1;

	localparam logic OP_COPY   = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CAP  = 4'b0010,
		ST_TREE = 4'b0100,
		ST_DEC  = 4'b1000
	} state_t;

	typedef struct packed {
		logic load_wr;
		logic clear;
		logic capture;
		logic take_ext;
		logic take_hit;
	} cell_ctl_t;

endpackage

@@ sv/gdci_cell.sv @@
`timescale 1ns / 1ps
// one original-buffer cell: stored byte, match end flag, candidate flags
// depends on gdci_pkg for the cell control struct
module gdci_cell #(
	parameter int CW  = 11,
	parameter int IDX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  gdci_pkg::cell_ctl_t ctl,
	input  logic [CW-1:0]       wr_idx,
	input  logic [CW-1:0]       count,
	input  logic [7:0]          data_byte,
	input  logic                prev_flag,
	output logic                flag,
	output logic                ext,
	output logic                hit
);

	localparam logic [CW-1:0] IDX_C = CW'(IDX);

	logic [7:0] byte_q;
	logic       hit_c;
	logic       flag_q;
	logic       ext_s1;
	logic       hit_s1;

	always_ff @(posedge clk) begin
		if (ctl.load_wr && (wr_idx == IDX_C)) begin
			byte_q <= data_byte;
		end
	end

	assign hit_c = (IDX_C < count) && (byte_q == data_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
			ext_s1 <= 1'b0;
			hit_s1 <= 1'b0;
		end else begin
			if (ctl.capture) begin
				ext_s1 <= prev_flag && hit_c;
				hit_s1 <= hit_c;
			end
			if (ctl.clear) begin
				flag_q <= 1'b0;
			end else if (ctl.take_ext) begin
				flag_q <= ext_s1;
			end else if (ctl.take_hit) begin
				flag_q <= hit_s1;
			end
		end
	end

	assign flag = flag_q;
	assign ext  = ext_s1;
	assign hit  = hit_s1;

endmodule

@@ sv/gdci_first.sv @@
`timescale 1ns / 1ps
// two-stage registered search for the lowest set bit of a flag row
// depends on nothing
module gdci_first #(
	parameter  int DEPTH = 1024,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [DEPTH-1:0] vec,
	output logic             any,
	output logic [AW-1:0]    first
);

	localparam int GB  = AW / 2;
	localparam int G   = 1 << GB;
	localparam int NG  = (DEPTH + G - 1) / G;
	localparam int NGB = AW - GB;
	localparam int LW  = (GB > 0) ? GB : 1;

	logic [NG*G-1:0]         pad;
	logic [NG-1:0]           gany_c;
	logic [NG-1:0]           gany_s1;
	logic [NG-1:0][LW-1:0]   loc_c;
	logic [NG-1:0][LW-1:0]   loc_s1;
	logic [NGB-1:0]          grp_c;
	logic [AW-1:0]           first_c;
	logic                    any_s2;
	logic [AW-1:0]           first_s2;

	assign pad = (NG*G)'(vec);

	always_comb begin
		for (int g = 0; g < NG; g++) begin
			gany_c[g] = |pad[g*G +: G];
			loc_c[g]  = '0;
			for (int i = G - 1; i >= 0; i--) begin
				if (pad[g*G + i]) begin
					loc_c[g] = LW'(i);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gany_s1 <= '0;
			any_s2  <= 1'b0;
		end else begin
			gany_s1 <= gany_c;
			any_s2  <= |gany_s1;
		end
	end

	always_ff @(posedge clk) begin
		loc_s1 <= loc_c;
	end

	always_comb begin
		grp_c = '0;
		for (int g = NG - 1; g >= 0; g--) begin
			if (gany_s1[g]) begin
				grp_c = NGB'(g);
			end
		end
		first_c = (AW'(grp_c) << GB) | AW'(loc_s1[grp_c]);
	end

	always_ff @(posedge clk) begin
		first_s2 <= first_c;
	end

	assign any   = any_s2;
	assign first = first_s2;

endmodule

@@ sv/greedy_delta_copy_insert_encoder_core.sv @@
`timescale 1ns / 1ps
// greedy copy/insert delta encoder: a loaded byte is stored in the cell row and gives no result
// an encoded byte passes capture in the cell row, two search stages and decide; decide waits for an empty result queue
// its results are registered into the result queue at decide; the next byte is accepted once decide is done
// the lowest-match search tree over the cell row accounts for the two search stages
// reset clears count, flags, pending length and result queue; stored bytes stay unknown
`include "greedy_delta_copy_insert_encoder_core_macros.svh"
module greedy_delta_copy_insert_encoder_core #(
	parameter  int ORIG_DEPTH = 1024,
	localparam int AW         = $clog2(ORIG_DEPTH),
	localparam int CW         = $clog2(ORIG_DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          func,
	input  logic [7:0]    data_byte,
	input  logic          last,
	output logic          out_valid,
	input  logic          out_stall,
	output logic          op_kind,
	output logic [AW-1:0] copy_position,
	output logic [CW-1:0] copy_length,
	output logic [7:0]    literal_byte,
	output logic          last_of_run,
	output logic          end_of_patch
);

	import gdci_pkg::*;

	typedef struct packed {
		logic          op_kind;
		logic [AW-1:0] pos;
		logic [CW-1:0] len;
		logic [7:0]    lit;
		logic          lrun;
		logic          eop;
	} res_t;

	function automatic res_t mk_copy(input logic [AW-1:0] pos, input logic [CW-1:0] len,
		input logic lrun, input logic eop);
		res_t r;
		r.op_kind = OP_COPY;
		r.pos     = pos;
		r.len     = len;
		r.lit     = '0;
		r.lrun    = lrun;
		r.eop     = eop;
		return r;
	endfunction

	function automatic res_t mk_insert(input logic [7:0] lit, input logic eop);
		res_t r;
		r.op_kind = OP_INSERT;
		r.pos     = '0;
		r.len     = CW'(1);
		r.lit     = lit;
		r.lrun    = 1'b1;
		r.eop     = eop;
		return r;
	endfunction

	state_t                state_q;
	logic [CW-1:0]         count_q;
	logic                  done_q;
	logic [CW-1:0]         len_q;
	logic [7:0]            byte_q;
	logic                  last_q;

	logic                  in_acc;
	logic                  load_acc;
	logic                  enc_acc;
	logic [CW-1:0]         base_c;
	logic                  room_c;
	cell_ctl_t             ctl_c;

	logic [ORIG_DEPTH-1:0] flag_v;
	logic [ORIG_DEPTH-1:0] prev_v;
	logic [ORIG_DEPTH-1:0] ext_v;
	logic [ORIG_DEPTH-1:0] hit_v;
	logic                  any_flag;
	logic                  any_ext;
	logic                  any_hit;
	logic [AW-1:0]         first_flag;
	logic [AW-1:0]         first_ext;
	logic [AW-1:0]         first_hit;

	logic                  dec_fire;
	logic                  take_ext_c;
	logic                  take_hit_c;
	logic                  clear_c;
	logic [CW-1:0]         len_nxt_c;
	logic [1:0]            nres_c;
	res_t                  res_a_c;
	res_t                  res_b_c;
	res_t                  new_c;

	res_t                  slot0_q;
	res_t                  slot1_q;
	logic [1:0]            cnt_q;
	logic                  pop;

	// input side
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign load_acc = in_acc && (func == FUNC_LOAD);
	assign enc_acc  = in_acc && (func == FUNC_ENCODE);
	assign base_c   = done_q ? '0 : count_q;
	assign room_c   = (base_c < CW'(ORIG_DEPTH));
	assign dec_fire = (state_q == ST_DEC) && (cnt_q == 2'd0);

	always_comb begin
		ctl_c.load_wr  = load_acc && room_c;
		ctl_c.clear    = load_acc || (dec_fire && clear_c);
		ctl_c.capture  = enc_acc;
		ctl_c.take_ext = dec_fire && take_ext_c;
		ctl_c.take_hit = dec_fire && take_hit_c;
	end

	// cell row
	assign prev_v = flag_v << 1;

	for (genvar q = 0; q < ORIG_DEPTH; q++) begin : g_cell
		gdci_cell #(
			.CW  (CW),
			.IDX (q)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl_c),
			.wr_idx    (base_c),
			.count     (count_q),
			.data_byte (data_byte),
			.prev_flag (prev_v[q]),
			.flag      (flag_v[q]),
			.ext       (ext_v[q]),
			.hit       (hit_v[q])
		);
	end

	gdci_first #(.DEPTH(ORIG_DEPTH)) u_first_flag (
		.clk    (clk),
		.arst_n (arst_n),
		.vec    (flag_v),
		.any    (any_flag),
		.first  (first_flag)
	);

	gdci_first #(.DEPTH(ORIG_DEPTH)) u_first_ext (
		.clk    (clk),
		.arst_n (arst_n),
		.vec    (ext_v),
		.any    (any_ext),
		.first  (first_ext)
	);

	gdci_first #(.DEPTH(ORIG_DEPTH)) u_first_hit (
		.clk    (clk),
		.arst_n (arst_n),
		.vec    (hit_v),
		.any    (any_hit),
		.first  (first_hit)
	);

	// decision
	always_comb begin
		res_a_c    = mk_insert(byte_q, last_q);
		res_b_c    = mk_insert(byte_q, last_q);
		new_c      = mk_insert(byte_q, last_q);
		nres_c     = 2'd0;
		take_ext_c = 1'b0;
		take_hit_c = 1'b0;
		clear_c    = 1'b0;
		len_nxt_c  = len_q;
		if ((len_q != '0) && any_ext) begin
			if (last_q) begin
				res_a_c   = mk_copy(first_ext - len_q[AW-1:0], len_q + CW'(1), 1'b1, 1'b1);
				nres_c    = 2'd1;
				clear_c   = 1'b1;
				len_nxt_c = '0;
			end else begin
				take_ext_c = 1'b1;
				len_nxt_c  = len_q + CW'(1);
			end
		end else begin
			if (len_q != '0) begin
				res_a_c = mk_copy(first_flag - len_q[AW-1:0] + AW'(1), len_q, 1'b0, 1'b0);
				nres_c  = 2'd1;
			end
			if (any_hit && !last_q) begin
				take_hit_c = 1'b1;
				len_nxt_c  = CW'(1);
				if (len_q != '0) begin
					res_a_c.lrun = 1'b1;
				end
			end else begin
				clear_c   = 1'b1;
				len_nxt_c = '0;
				if (any_hit) begin
					new_c = mk_copy(first_hit, CW'(1), 1'b1, 1'b1);
				end
				if (len_q != '0) begin
					res_b_c = new_c;
				end else begin
					res_a_c = new_c;
				end
				nres_c = nres_c + 2'd1;
			end
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
			len_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (enc_acc) begin
						state_q <= ST_CAP;
					end
				end
				ST_CAP: begin
					state_q <= ST_TREE;
				end
				ST_TREE: begin
					state_q <= ST_DEC;
				end
				ST_DEC: begin
					if (dec_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (load_acc) begin
				count_q <= room_c ? (base_c + CW'(1)) : base_c;
				done_q  <= last;
				len_q   <= '0;
			end else if (dec_fire) begin
				len_q <= len_nxt_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (enc_acc) begin
			byte_q <= data_byte;
			last_q <= last;
		end
	end

	// result queue
	assign pop = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (dec_fire) begin
			cnt_q <= nres_c;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (dec_fire) begin
			slot0_q <= res_a_c;
			slot1_q <= res_b_c;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

	assign out_valid     = (cnt_q != 2'd0);
	assign op_kind       = slot0_q.op_kind;
	assign copy_position = slot0_q.pos;
	assign copy_length   = slot0_q.len;
	assign literal_byte  = slot0_q.lit;
	assign last_of_run   = slot0_q.lrun;
	assign end_of_patch  = slot0_q.eop;

	`GDCI_ASSERT_IMP(a_cap_follows_enc, clk, arst_n, state_q == ST_CAP, $past(enc_acc), "capture without encode beat")
	`GDCI_ASSERT_NXT(a_ext_grows, clk, arst_n, ctl_c.take_ext, len_q == $past(len_q) + CW'(1), "extend did not grow length")
	`GDCI_ASSERT_IMP(a_pending_has_flags, clk, arst_n, dec_fire && (len_q != '0), any_flag, "pending symbol with no match flag")
	`GDCI_ASSERT_IMP(a_len_bound, clk, arst_n, state_q == ST_IDLE, len_q <= count_q, "pending length beyond original")
	`GDCI_ASSERT_NXT(a_fire_fills, clk, arst_n, dec_fire && (nres_c != 2'd0), out_valid, "decided results not shown")
	`GDCI_ASSERT_IMP(a_eop_ends_run, clk, arst_n, out_valid && end_of_patch, last_of_run, "end of patch not last of run")

endmodule
